// ===== rtl/pcwpm_pkg.sv =====
package pcwpm_pkg;

  localparam int CHANNELS = 25;
  localparam int CH_W     = 5;
  localparam int ADDR_W   = $clog2(CHANNELS);
  localparam int SMP_W    = 16;
  localparam int MAG_W    = 15;
  localparam int POS_W    = 16;

  localparam logic [POS_W-1:0] WINDOW_RESET = 16'd735;

  // One channel's stored state.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [MAG_W-1:0] peak_l;
    logic [MAG_W-1:0] peak_r;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Magnitude of a 16-bit two's complement sample; -32768 saturates.
  function automatic logic [MAG_W-1:0] magnitude(input logic [SMP_W-1:0] v);
    logic [SMP_W-1:0] neg;
    neg = ~v + 1'b1;
    if (!v[SMP_W-1]) begin
      magnitude = v[MAG_W-1:0];
    end else if (neg[SMP_W-1]) begin
      magnitude = {MAG_W{1'b1}};
    end else begin
      magnitude = neg[MAG_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/pcwpm_ram.sv =====
module pcwpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns old data on a same-address write; rdata holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pcwpm_update.sv =====
module pcwpm_update (
  input  pcwpm_pkg::entry_t                 cur,
  input  logic [pcwpm_pkg::MAG_W-1:0]       mag_l,
  input  logic [pcwpm_pkg::MAG_W-1:0]       mag_r,
  input  logic [pcwpm_pkg::POS_W-1:0]       window_samples,
  output pcwpm_pkg::entry_t                 nxt,
  output logic                              start
);

  logic [pcwpm_pkg::POS_W-1:0] win;
  logic [pcwpm_pkg::POS_W:0]   pos_inc;

  always_comb begin
    win     = (window_samples == '0) ? pcwpm_pkg::POS_W'(1) : window_samples;
    pos_inc = {1'b0, cur.pos} + 1'b1;
    start   = (cur.pos == '0);

    if (start) begin
      nxt.peak_l = mag_l;
      nxt.peak_r = mag_r;
    end else begin
      nxt.peak_l = (mag_l > cur.peak_l) ? mag_l : cur.peak_l;
      nxt.peak_r = (mag_r > cur.peak_r) ? mag_r : cur.peak_r;
    end

    // Wrap once the window is full; also catches a shortened window.
    if (pos_inc >= {1'b0, win}) begin
      nxt.pos = '0;
    end else begin
      nxt.pos = pos_inc[pcwpm_pkg::POS_W-1:0];
    end
  end

endmodule

// ===== rtl/per_channel_windowed_peak_meter_top.sv =====
// Per-channel windowed peak meter.
//
// Input channel (in_valid/in_ready): one word per stereo sample pair, tagged
// with its channel number (0..24, 24 is the master mix). Output channel
// (out_valid/out_ready): one word per input word, in order, carrying the
// channel's updated left/right peak magnitudes and a flag marking the first
// sample of a new peak window. Config channel (cfg_valid/cfg_ready): one word
// sets window_samples (0 acts as 1); write only while the meter is idle.
//
// An accepted word is registered in the update stage, then in the output
// register. Throughput is one word per cycle while out_ready stays high:
// per-channel state sits in a 25-entry RAM, read when the word is accepted
// and written back as it leaves the update stage. A same-channel word
// accepted during that write-back gets the fresh state via a forwarding register.
//
// Reset clears all flow control, loads window_samples with 735, and marks
// every channel entry as empty, so it reads as zero until first written.
// When the receiver stalls, the output register holds its word, the update
// stage holds one more, and in_ready drops; nothing is lost or repeated.
// Channel numbers 25..31 leave state alone and report zero peaks.
module per_channel_windowed_peak_meter_top (
  input  logic                              clk,
  input  logic                              rst,
  // config
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcwpm_pkg::POS_W-1:0]       cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pcwpm_pkg::CH_W-1:0]        channel,
  input  logic signed [pcwpm_pkg::SMP_W-1:0] left_sample,
  input  logic signed [pcwpm_pkg::SMP_W-1:0] right_sample,
  // output words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcwpm_pkg::CH_W-1:0]        out_channel,
  output logic [pcwpm_pkg::MAG_W-1:0]       peak_left,
  output logic [pcwpm_pkg::MAG_W-1:0]       peak_right,
  output logic                              window_start
);

  logic [pcwpm_pkg::POS_W-1:0] window_samples;

  // update stage (s1)
  logic                          s1_valid;
  logic                          s1_in_range;
  logic [pcwpm_pkg::CH_W-1:0]    s1_channel;
  logic [pcwpm_pkg::MAG_W-1:0]   s1_mag_l;
  logic [pcwpm_pkg::MAG_W-1:0]   s1_mag_r;
  logic                          s1_entry_ok;   // entry written since reset
  logic                          s1_fwd;        // same-cycle write hit our read
  pcwpm_pkg::entry_t             s1_fwd_data;

  logic [pcwpm_pkg::CHANNELS-1:0] entry_valid;

  logic                          in_fire;
  logic                          in_range;
  logic                          s1_adv;
  logic                          wr_en;
  logic [pcwpm_pkg::ADDR_W-1:0]  rd_addr;
  logic [pcwpm_pkg::ADDR_W-1:0]  wr_addr;
  logic [pcwpm_pkg::ENTRY_W-1:0] ram_rdata;
  pcwpm_pkg::entry_t             cur;
  pcwpm_pkg::entry_t             nxt;
  logic                          start;

  assign cfg_ready = 1'b1;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign in_range = (channel < pcwpm_pkg::CH_W'(pcwpm_pkg::CHANNELS));
  assign rd_addr  = channel[pcwpm_pkg::ADDR_W-1:0];
  assign wr_addr  = s1_channel[pcwpm_pkg::ADDR_W-1:0];
  assign wr_en    = s1_adv && s1_in_range;

  pcwpm_ram #(
    .WIDTH (pcwpm_pkg::ENTRY_W),
    .DEPTH (pcwpm_pkg::CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (nxt),
    .re    (in_fire && in_range),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Current entry: forwarded write, empty entry (zero), or RAM data.
  always_comb begin
    if (s1_fwd) begin
      cur = s1_fwd_data;
    end else if (!s1_entry_ok) begin
      cur = '0;
    end else begin
      cur = ram_rdata;
    end
  end

  pcwpm_update u_update (
    .cur            (cur),
    .mag_l          (s1_mag_l),
    .mag_r          (s1_mag_r),
    .window_samples (window_samples),
    .nxt            (nxt),
    .start          (start)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples <= pcwpm_pkg::WINDOW_RESET;
      entry_valid    <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_samples <= cfg_data;
      end
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: update stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_in_range <= in_range;
      s1_channel  <= channel;
      s1_mag_l    <= pcwpm_pkg::magnitude(left_sample);
      s1_mag_r    <= pcwpm_pkg::magnitude(right_sample);
      s1_entry_ok <= in_range && entry_valid[rd_addr];
      s1_fwd      <= in_range && wr_en && (wr_addr == rd_addr);
      s1_fwd_data <= nxt;
    end
  end

  // Payload: output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_channel <= s1_channel;
      if (s1_in_range) begin
        peak_left    <= nxt.peak_l;
        peak_right   <= nxt.peak_r;
        window_start <= start;
      end else begin
        peak_left    <= '0;
        peak_right   <= '0;
        window_start <= 1'b0;
      end
    end
  end

endmodule
